### rtl/rrqs_pkg.sv
`default_nettype none

package rrqs_pkg;

    typedef enum logic [1:0] {
        MODE_TICK    = 2'd0,
        MODE_READY   = 2'd1,
        MODE_QUANTUM = 2'd2
    } mode_t;

    localparam int TASK_ID_W = 4;
    localparam int QUANTUM_W = 16;
    localparam int TASK_SPACE = 1 << TASK_ID_W;

    localparam logic [TASK_ID_W-1:0] FIRST_TASK   = 4'd1;
    localparam logic [QUANTUM_W-1:0] INIT_QUANTUM = 16'd15;
    localparam logic [QUANTUM_W-1:0] MIN_QUANTUM  = 16'd1;

endpackage

`default_nettype wire

### rtl/rrqs_if.sv
`default_nettype none

interface rrqs_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [3:0]  task_id;
    logic [15:0] quantum_value;

    modport source (output valid, output mode, output task_id, output quantum_value,
                    input ready);
    modport sink (input valid, input mode, input task_id, input quantum_value,
                  output ready);
endinterface

interface rrqs_res_if;
    logic        valid;
    logic        ready;
    logic        switched;
    logic [3:0]  running_task;
    logic [15:0] ticks_left;
    logic        rejected;

    modport source (output valid, output switched, output running_task,
                    output ticks_left, output rejected, input ready);
    modport sink (input valid, input switched, input running_task,
                  input ticks_left, input rejected, output ready);
endinterface

`default_nettype wire

### rtl/round_robin_quantum_scheduler.sv
// a command word is held in the input stage register, its result word in the result
// stage register; throughput: one word per cycle unless res.ready stalls the output;
// the ready queue ram reads the next head slot into its registered output, with a
// bypass when that slot is written in the same cycle; reset: asynchronous, clears the
// queue to empty, makes task one current with a slice of fifteen and loads fifteen
// into every quantum entry; queue ram contents are left as they are
`default_nettype none

module round_robin_quantum_scheduler
    import rrqs_pkg::*;
#(
    parameter int NUM_TASKS = 16
) (
    input wire logic  clk,
    input wire logic  rst_n,
    rrqs_cmd_if.sink  cmd,
    rrqs_res_if.source res
);

    localparam int AW = $clog2(NUM_TASKS);
    localparam int CW = $clog2(NUM_TASKS + 1);
    localparam int QD = (NUM_TASKS < TASK_SPACE) ? NUM_TASKS : TASK_SPACE;
    localparam int QW = $clog2(QD);
    localparam logic [AW-1:0] LAST_SLOT  = AW'(NUM_TASKS - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(NUM_TASKS);
    localparam logic [AW:0]   WRAP_SUM   = (AW + 1)'(NUM_TASKS);

    // input stage
    logic                 in_valid_reg;
    logic [1:0]           in_mode_reg;
    logic [TASK_ID_W-1:0] in_tid_reg;
    logic [QUANTUM_W-1:0] in_qv_reg;

    // scheduler state
    logic [AW-1:0]        head_reg, head_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [TASK_ID_W-1:0] current_reg, current_next;
    logic [QUANTUM_W-1:0] slice_reg, slice_next;
    logic [QUANTUM_W-1:0] qtab_reg [QD];

    // head bypass
    logic                 byp_reg, byp_next;
    logic [TASK_ID_W-1:0] byp_data_reg;

    // result stage
    logic                 out_valid_reg;
    logic                 switched_reg, switched_next;
    logic                 rejected_reg, rejected_next;
    logic [TASK_ID_W-1:0] running_reg;
    logic [QUANTUM_W-1:0] ticks_reg;

    logic                 adv;
    logic                 out_free;
    logic                 tid_ok;
    logic [AW:0]          tail_sum;
    logic [AW-1:0]        tail;
    logic [AW-1:0]        head_inc;
    logic [TASK_ID_W-1:0] head_val;
    logic [TASK_ID_W-1:0] ram_rdata;
    logic [QUANTUM_W-1:0] dec;
    logic [TASK_ID_W-1:0] sel_task;
    logic                 fifo_we;
    logic [TASK_ID_W-1:0] fifo_wdata;
    logic                 q_we;
    logic [QUANTUM_W-1:0] q_wdata;

    assign out_free  = !out_valid_reg || res.ready;
    assign adv       = in_valid_reg && out_free;
    assign cmd.ready = !in_valid_reg || out_free;

    assign tid_ok   = 32'(in_tid_reg) < NUM_TASKS;
    assign tail_sum = (AW + 1)'(head_reg) + (AW + 1)'(count_reg);
    assign tail     = (tail_sum >= WRAP_SUM) ? AW'(tail_sum - WRAP_SUM) : AW'(tail_sum);
    assign head_inc = (head_reg == LAST_SLOT) ? '0 : head_reg + AW'(1);
    assign head_val = byp_reg ? byp_data_reg : ram_rdata;
    assign dec      = slice_reg - MIN_QUANTUM;
    assign q_wdata  = (in_qv_reg == '0) ? MIN_QUANTUM : in_qv_reg;

    always_comb
    begin
        head_next     = head_reg;
        count_next    = count_reg;
        current_next  = current_reg;
        slice_next    = slice_reg;
        switched_next = 1'b0;
        rejected_next = 1'b0;
        fifo_we       = 1'b0;
        fifo_wdata    = in_tid_reg;
        q_we          = 1'b0;
        sel_task      = current_reg;
        if (adv)
        begin
            unique case (in_mode_reg)
                MODE_TICK:
                begin
                    if (dec == '0)
                    begin
                        if (count_reg != '0)
                        begin
                            // rotate: current goes to the tail, head becomes current
                            sel_task      = head_val;
                            fifo_we       = 1'b1;
                            fifo_wdata    = current_reg;
                            head_next     = head_inc;
                            switched_next = 1'b1;
                        end
                        current_next = sel_task;
                        slice_next   = qtab_reg[sel_task[QW-1:0]];
                    end
                    else
                    begin
                        slice_next = dec;
                    end
                end
                MODE_READY:
                begin
                    if (tid_ok)
                    begin
                        if (count_reg == FULL_COUNT)
                        begin
                            rejected_next = 1'b1;
                        end
                        else
                        begin
                            fifo_we    = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                end
                MODE_QUANTUM:
                begin
                    q_we = tid_ok;
                end
                default:
                begin
                end
            endcase
        end
    end

    // next head slot is written this cycle: take the word from the write side
    assign byp_next = fifo_we && (tail == head_next);

    rrqs_ram #(
        .WIDTH (TASK_ID_W),
        .DEPTH (NUM_TASKS)
    ) u_fifo_ram (
        .clk   (clk),
        .we    (fifo_we),
        .waddr (tail),
        .wdata (fifo_wdata),
        .raddr (head_next),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            head_reg      <= '0;
            count_reg     <= '0;
            current_reg   <= FIRST_TASK;
            slice_reg     <= INIT_QUANTUM;
            byp_reg       <= 1'b0;
            for (int i = 0; i < QD; i++)
            begin
                qtab_reg[i] <= INIT_QUANTUM;
            end
        end
        else
        begin
            if (cmd.ready)
            begin
                in_valid_reg <= cmd.valid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            head_reg    <= head_next;
            count_reg   <= count_next;
            current_reg <= current_next;
            slice_reg   <= slice_next;
            byp_reg     <= byp_next;
            if (q_we)
            begin
                qtab_reg[in_tid_reg[QW-1:0]] <= q_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= fifo_wdata;
        if (cmd.valid && cmd.ready)
        begin
            in_mode_reg <= cmd.mode;
            in_tid_reg  <= cmd.task_id;
            in_qv_reg   <= cmd.quantum_value;
        end
        if (adv)
        begin
            switched_reg <= switched_next;
            rejected_reg <= rejected_next;
            running_reg  <= current_next;
            ticks_reg    <= slice_next;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.switched     = switched_reg;
    assign res.running_task = running_reg;
    assign res.ticks_left   = ticks_reg;
    assign res.rejected     = rejected_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("ready queue count above capacity");

    a_current_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(current_reg) < NUM_TASKS)
        else $error("current task outside task range");

    a_switch_slice: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.switched |-> res.ticks_left != '0)
        else $error("switch loaded an empty slice");

    a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.rejected |-> count_reg == FULL_COUNT)
        else $error("reject reported while queue not full");
`endif

endmodule

`default_nettype wire

### rtl/rrqs_ram.sv
`default_nettype none

module rrqs_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
